>>> rtl/core/aols_pkg.sv
// shared types and constants for the audio onset and level statistics unit
package aols_pkg;

  localparam int SampleW = 16;
  localparam int OutCntW = 24;
  localparam int ThreshW = 15;
  localparam int WindowW = 16;

  localparam logic [ThreshW-1:0] ThreshReset = 15'd150;
  localparam logic [WindowW-1:0] WindowReset = 16'd300;
  localparam logic signed [SampleW-1:0] SampleMax = 16'sh7fff;
  localparam logic signed [SampleW-1:0] SampleMin = -16'sh8000;

  // register index, taken from paddr[2]
  localparam logic RegThreshold = 1'b0;
  localparam logic RegWindow    = 1'b1;

  typedef struct packed {
    logic signed [SampleW-1:0] sample;
    logic                      last;
  } item_t;

  typedef struct packed {
    logic [OutCntW-1:0]        sample_count;
    logic                      onset_found;
    logic [OutCntW-1:0]        onset_index;
    logic [SampleW-1:0]        attack_peak;
    logic [SampleW-1:0]        record_peak;
    logic signed [SampleW-1:0] min_sample;
    logic signed [SampleW-1:0] max_sample;
    logic [OutCntW-1:0]        clipped_count;
  } result_t;

  typedef struct packed {
    logic [ThreshW-1:0] threshold;
    logic [WindowW-1:0] window;
  } cfg_t;

endpackage

>>> rtl/core/aols_in_stage.sv
// input register holding one sample item until the statistics stage takes it
module aols_in_stage
  import aols_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  in_valid_i,
  output logic  in_ready_o,
  input  item_t in_item_i,
  input  logic  step_i,
  output logic  stg_valid_o,
  output item_t stg_item_o
);

  logic  valid_q, valid_d;
  item_t item_q;
  logic  take;

  assign in_ready_o = !valid_q || step_i;
  assign take       = in_valid_i && in_ready_o;
  assign valid_d    = take ? 1'b1 : (step_i ? 1'b0 : valid_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      item_q <= in_item_i;
    end
  end

  assign stg_valid_o = valid_q;
  assign stg_item_o  = item_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_q && !step_i) |=> (valid_q && $stable(item_q)))
    else $error("held item lost or changed");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!valid_q) |-> in_ready_o)
    else $error("empty stage not ready");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (take && !step_i && valid_q) |-> 1'b0)
    else $error("item taken over an unprocessed one");

endmodule

>>> rtl/core/aols_stats.sv
// record state: count, extremes, clip tally, onset and onset window peak
module aols_stats
  import aols_pkg::*;
#(
  parameter int COUNT_BITS = 24
) (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    step_i,
  input  item_t   item_i,
  input  cfg_t    cfg_i,
  output result_t result_o
);

  logic [COUNT_BITS-1:0]     cnt_q, cnt_d, clip_q, clip_d, pos_q, pos_d;
  logic                      seen_q, seen_d;
  logic [WindowW-1:0]        wl_q, wl_d, wl_sel;
  logic [SampleW-1:0]        wpk_q, wpk_d;
  logic signed [SampleW-1:0] min_q, min_d, max_q, max_d;
  logic [SampleW-1:0]        mag;
  logic                      found_now;
  logic signed [SampleW:0]   neg_min, max_ext, peak;

  always_comb begin
    mag       = item_i.sample[SampleW-1] ? SampleW'(~item_i.sample + 1'b1)
                                         : item_i.sample;
    found_now = !seen_q && (mag > {1'b0, cfg_i.threshold});

    min_d  = (item_i.sample < min_q) ? item_i.sample : min_q;
    max_d  = (item_i.sample > max_q) ? item_i.sample : max_q;
    clip_d = clip_q;
    if ((item_i.sample == SampleMax || item_i.sample == SampleMin) && clip_q != '1) begin
      clip_d = clip_q + 1'b1;
    end

    seen_d = seen_q || found_now;
    pos_d  = found_now ? cnt_q : pos_q;
    wl_sel = found_now ? cfg_i.window : wl_q;
    wl_d   = wl_sel;
    wpk_d  = wpk_q;
    if (seen_d && wl_sel != '0) begin
      if (mag > wpk_q) begin
        wpk_d = mag;
      end
      wl_d = wl_sel - 1'b1;
    end

    cnt_d = (cnt_q != '1) ? cnt_q + 1'b1 : cnt_q;

    // overall peak is max(max, -min), up to 32768
    neg_min = -{min_d[SampleW-1], min_d};
    max_ext = {max_d[SampleW-1], max_d};
    peak    = (max_ext > neg_min) ? max_ext : neg_min;

    result_o.sample_count  = OutCntW'(cnt_d);
    result_o.onset_found   = seen_d;
    result_o.onset_index   = seen_d ? OutCntW'(pos_d) : '0;
    result_o.attack_peak   = seen_d ? wpk_d : '0;
    result_o.record_peak   = peak[SampleW-1:0];
    result_o.min_sample    = min_d;
    result_o.max_sample    = max_d;
    result_o.clipped_count = OutCntW'(clip_d);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      clip_q <= '0;
      pos_q  <= '0;
      seen_q <= 1'b0;
      wl_q   <= '0;
      wpk_q  <= '0;
      min_q  <= SampleMax;
      max_q  <= SampleMin;
    end else if (step_i) begin
      if (item_i.last) begin
        // record done, start a fresh one
        cnt_q  <= '0;
        clip_q <= '0;
        pos_q  <= '0;
        seen_q <= 1'b0;
        wl_q   <= '0;
        wpk_q  <= '0;
        min_q  <= SampleMax;
        max_q  <= SampleMin;
      end else begin
        cnt_q  <= cnt_d;
        clip_q <= clip_d;
        pos_q  <= pos_d;
        seen_q <= seen_d;
        wl_q   <= wl_d;
        wpk_q  <= wpk_d;
        min_q  <= min_d;
        max_q  <= max_d;
      end
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q != '0) |-> (min_q <= max_q))
    else $error("record minimum above maximum");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (wl_q != '0 || wpk_q != '0) |-> seen_q)
    else $error("onset window active without onset");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step_i && item_i.last) |=> (cnt_q == '0 && !seen_q && clip_q == '0))
    else $error("record state not cleared after last item");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (clip_q <= cnt_q))
    else $error("clip tally above sample count");

endmodule

>>> rtl/core/aols_out_stage.sv
// result register; holds a finished result until the receiver takes it
module aols_out_stage
  import aols_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    load_i,
  input  result_t result_i,
  output logic    can_load_o,
  output logic    out_valid_o,
  input  logic    out_ready_i,
  output result_t result_o
);

  logic    valid_q, valid_d;
  result_t res_q;

  assign can_load_o = !valid_q || out_ready_i;
  assign valid_d    = load_i ? 1'b1 : (out_ready_i ? 1'b0 : valid_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      res_q <= result_i;
    end
  end

  assign out_valid_o = valid_q;
  assign result_o    = res_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_i |-> can_load_o)
    else $error("result overwritten before it was taken");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_i |=> (valid_q && res_q == $past(result_i)))
    else $error("loaded result not presented");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_q && !out_ready_i) |=> valid_q)
    else $error("stalled result dropped");

endmodule

>>> rtl/core/audio_onset_and_level_stats_unit.sv
// top level of the audio onset and level statistics unit
//
// Samples come in on a valid/ready channel (sample_i, last_i); a record ends
// with the item that has last_i high. For each record exactly one result
// leaves on the output valid/ready channel: sample count, onset flag, onset
// index, peak within the onset window, overall peak, minimum, maximum and
// clipped-sample count. Non-last items produce no result.
// An item is registered in the input register at acceptance; a non-last
// item is processed the next cycle, a last item once the result register
// can load. Throughput: one item per cycle while no last item is held back,
// set by the single statistics update between the two registers.
// When the receiver stalls, the finished result waits in the result register
// while further samples of the next record keep flowing; only a second last
// item is held back until the waiting result is taken.
// Configuration: APB write at 0x0 sets the silence threshold, at 0x4 the onset
// window; write only while idle. Reset (rst_ni low) clears the record state,
// empties both registers and restores threshold 150 and window 300.
module audio_onset_and_level_stats_unit
  import aols_pkg::*;
#(
  parameter int COUNT_BITS = 24
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [2:0]                paddr,
  input  logic [31:0]               pwdata,
  output logic [31:0]               prdata,
  output logic                      pready,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  logic signed [SampleW-1:0] sample_i,
  input  logic                      last_i,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output logic [OutCntW-1:0]        sample_count_o,
  output logic                      onset_found_o,
  output logic [OutCntW-1:0]        onset_index_o,
  output logic [SampleW-1:0]        attack_peak_o,
  output logic [SampleW-1:0]        record_peak_o,
  output logic signed [SampleW-1:0] min_sample_o,
  output logic signed [SampleW-1:0] max_sample_o,
  output logic [OutCntW-1:0]        clipped_count_o
);

  cfg_t    cfg_q;
  item_t   in_item, stg_item;
  logic    stg_valid, step, can_load, load, cfg_wr;
  result_t stats_res, out_res;

  // configuration registers
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.threshold <= ThreshReset;
      cfg_q.window    <= WindowReset;
    end else if (cfg_wr) begin
      case (paddr[2])
        RegThreshold: cfg_q.threshold <= pwdata[ThreshW-1:0];
        RegWindow:    cfg_q.window    <= pwdata[WindowW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      RegThreshold: prdata = 32'(cfg_q.threshold);
      RegWindow:    prdata = 32'(cfg_q.window);
      default:      prdata = '0;
    endcase
  end

  // a last item waits only while an earlier result is still unread
  assign in_item.sample = sample_i;
  assign in_item.last   = last_i;
  assign step = stg_valid && (!stg_item.last || can_load);
  assign load = step && stg_item.last;

  aols_in_stage u_in_stage (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_item_i   (in_item),
    .step_i      (step),
    .stg_valid_o (stg_valid),
    .stg_item_o  (stg_item)
  );

  aols_stats #(
    .COUNT_BITS (COUNT_BITS)
  ) u_stats (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (step),
    .item_i   (stg_item),
    .cfg_i    (cfg_q),
    .result_o (stats_res)
  );

  aols_out_stage u_out_stage (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (load),
    .result_i    (stats_res),
    .can_load_o  (can_load),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .result_o    (out_res)
  );

  assign sample_count_o  = out_res.sample_count;
  assign onset_found_o   = out_res.onset_found;
  assign onset_index_o   = out_res.onset_index;
  assign attack_peak_o   = out_res.attack_peak;
  assign record_peak_o   = out_res.record_peak;
  assign min_sample_o    = out_res.min_sample;
  assign max_sample_o    = out_res.max_sample;
  assign clipped_count_o = out_res.clipped_count;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (stg_valid && !stg_item.last) |-> step)
    else $error("non-last item stalled");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (stg_valid && stg_item.last && out_valid_o && !out_ready_i) |-> !in_ready_o)
    else $error("input taken while last item blocked");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (onset_found_o || (onset_index_o == '0 && attack_peak_o == '0)))
    else $error("onset fields set without onset");

endmodule
